// ----- design/wpd_pkg.sv -----
// Shared types and constants for the WAV PCM stream decoder.
// Used by the parser, the result buffer and the top level; no dependencies.
`default_nettype none
package wpd_pkg;

   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam logic [31:0] FMT_CHUNK_SIZE = 32'd16;
   localparam logic [7:0]  SAMPLE_OFFSET  = 8'h80;

   localparam int RATE_WIDTH = 18;
   localparam logic [RATE_WIDTH-1:0] MIN_RATE_RESET = 18'd8000;
   localparam logic [RATE_WIDTH-1:0] MAX_RATE_RESET = 18'd48000;

   localparam logic CSR_IDX_MIN_RATE = 1'b0;
   localparam logic CSR_IDX_MAX_RATE = 1'b1;

   localparam logic [3:0] ERR_NONE     = 4'd0;
   localparam logic [3:0] ERR_RIFF     = 4'd1;
   localparam logic [3:0] ERR_WAVE     = 4'd2;
   localparam logic [3:0] ERR_FMT_TAG  = 4'd3;
   localparam logic [3:0] ERR_FMT_SIZE = 4'd4;
   localparam logic [3:0] ERR_NOT_PCM  = 4'd5;
   localparam logic [3:0] ERR_CHANNELS = 4'd6;
   localparam logic [3:0] ERR_RATE     = 4'd7;
   localparam logic [3:0] ERR_BITS     = 4'd8;

   typedef enum logic [1:0] {
      KIND_SAMPLE = 2'd0,
      KIND_HEADER = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic signed [15:0]     sample;
      logic                   channel;
      logic                   last_sample;
      logic [3:0]             error_code;
      logic [1:0]             channel_count;
      logic [5:0]             bits_per_sample;
      logic [RATE_WIDTH-1:0]  sample_rate;
      logic [31:0]            data_bytes;
   } rsp_type;

endpackage
`default_nettype wire

// ----- design/wpd_parser.sv -----
// Byte-serial RIFF/WAVE header parser and PCM sample converter.
// Depends on wpd_pkg; produces at most one result per accepted byte.
`default_nettype none
module wpd_parser (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           accept,
   input  wire logic [7:0]                     data_byte,
   input  wire logic                           file_start,
   input  wire logic [wpd_pkg::RATE_WIDTH-1:0] min_rate,
   input  wire logic [wpd_pkg::RATE_WIDTH-1:0] max_rate,
   output logic                                res_valid,
   output wpd_pkg::rsp_type                    res
);

   typedef enum logic [4:0] {
      PH_RIFF, PH_RSIZE, PH_WAVE, PH_FMT, PH_FSIZE, PH_AFMT, PH_CHAN, PH_RATE,
      PH_BRATE, PH_ALIGN, PH_BITS, PH_CID, PH_CSIZE, PH_SKIP, PH_DSIZE,
      PH_DATA, PH_DONE, PH_ERR
   } phase_type;

   phase_type   phase_ff, phase_in, cur_phase;
   logic [1:0]  field_idx_ff, field_idx_in, cur_field_idx;
   logic [31:0] word_ff, word_in, cur_word;
   logic [1:0]  chans_ff, chans_in, cur_chans;
   logic [5:0]  bits_ff, bits_in, cur_bits;
   logic [wpd_pkg::RATE_WIDTH-1:0] rate_ff, rate_in, cur_rate;
   logic [31:0] data_left_ff, data_left_in, cur_data_left;
   logic [31:0] skip_left_ff, skip_left_in, cur_skip_left;
   logic        chan_ff, chan_in, cur_chan;
   logic [1:0]  samp_idx_ff, samp_idx_in, cur_samp_idx;

   logic [1:0]  byte_idx;
   logic [31:0] word_new;
   logic        len_two;
   logic        field_last;
   logic [1:0]  nbytes_m1;
   logic [31:0] data_left_dec;
   logic [31:0] skip_left_dec;
   logic        rate_low;
   logic        rate_high;

   // A file start restarts the parser before the byte is taken.
   always_comb begin
      cur_phase     = file_start ? PH_RIFF : phase_ff;
      cur_field_idx = file_start ? 2'd0 : field_idx_ff;
      cur_word      = file_start ? 32'd0 : word_ff;
      cur_chans     = file_start ? 2'd0 : chans_ff;
      cur_bits      = file_start ? 6'd0 : bits_ff;
      cur_rate      = file_start ? '0 : rate_ff;
      cur_data_left = file_start ? 32'd0 : data_left_ff;
      cur_skip_left = file_start ? 32'd0 : skip_left_ff;
      cur_chan      = file_start ? 1'b0 : chan_ff;
      cur_samp_idx  = file_start ? 2'd0 : samp_idx_ff;
   end

   always_comb begin
      len_two = (cur_phase == PH_AFMT) || (cur_phase == PH_CHAN) ||
                (cur_phase == PH_ALIGN) || (cur_phase == PH_BITS);
      field_last = len_two ? (cur_field_idx == 2'd1) : (cur_field_idx == 2'd3);
      byte_idx = (cur_phase == PH_DATA) ? cur_samp_idx : cur_field_idx;
      word_new = ((byte_idx == 2'd0) ? 32'd0 : cur_word) |
                 ({24'd0, data_byte} << {byte_idx, 3'b000});
      case (cur_bits)
         6'd16:   nbytes_m1 = 2'd1;
         6'd32:   nbytes_m1 = 2'd3;
         default: nbytes_m1 = 2'd0;
      endcase
      data_left_dec = cur_data_left - 32'd1;
      skip_left_dec = cur_skip_left - 32'd1;
      rate_low  = word_new < {{(32-wpd_pkg::RATE_WIDTH){1'b0}}, min_rate};
      rate_high = word_new > {{(32-wpd_pkg::RATE_WIDTH){1'b0}}, max_rate};
   end

   always_comb begin
      phase_in     = cur_phase;
      field_idx_in = cur_field_idx;
      word_in      = cur_word;
      chans_in     = cur_chans;
      bits_in      = cur_bits;
      rate_in      = cur_rate;
      data_left_in = cur_data_left;
      skip_left_in = cur_skip_left;
      chan_in      = cur_chan;
      samp_idx_in  = cur_samp_idx;
      res_valid    = 1'b0;
      res          = '0;
      res.kind     = wpd_pkg::KIND_SAMPLE;

      case (cur_phase)
         PH_ERR, PH_DONE: begin
         end
         PH_DATA: begin
            word_in      = word_new;
            data_left_in = data_left_dec;
            if (data_left_dec == 32'd0) begin
               phase_in = PH_DONE;
            end
            if (cur_samp_idx != nbytes_m1) begin
               samp_idx_in = cur_samp_idx + 2'd1;
            end else begin
               samp_idx_in     = 2'd0;
               res_valid       = 1'b1;
               res.kind        = wpd_pkg::KIND_SAMPLE;
               res.channel     = cur_chan;
               res.last_sample = data_left_dec <= {30'd0, nbytes_m1};
               case (nbytes_m1)
                  2'd1:    res.sample = word_new[15:0];
                  2'd3:    res.sample = word_new[31:16];
                  default: res.sample = {word_new[7:0] ^ wpd_pkg::SAMPLE_OFFSET, 8'h00};
               endcase
               chan_in = (cur_chans == 2'd2) ? ~cur_chan : 1'b0;
            end
         end
         PH_SKIP: begin
            skip_left_in = skip_left_dec;
            if (skip_left_dec == 32'd0) begin
               phase_in = PH_CID;
            end
         end
         default: begin
            word_in = word_new;
            if (!field_last) begin
               field_idx_in = cur_field_idx + 2'd1;
            end else begin
               field_idx_in = 2'd0;
               case (cur_phase)
                  PH_RIFF: begin
                     if (word_new != wpd_pkg::TAG_RIFF) begin
                        phase_in = PH_ERR;
                        res.error_code = wpd_pkg::ERR_RIFF;
                     end else begin
                        phase_in = PH_RSIZE;
                     end
                  end
                  PH_RSIZE: phase_in = PH_WAVE;
                  PH_WAVE: begin
                     if (word_new != wpd_pkg::TAG_WAVE) begin
                        phase_in = PH_ERR;
                        res.error_code = wpd_pkg::ERR_WAVE;
                     end else begin
                        phase_in = PH_FMT;
                     end
                  end
                  PH_FMT: begin
                     if (word_new != wpd_pkg::TAG_FMT) begin
                        phase_in = PH_ERR;
                        res.error_code = wpd_pkg::ERR_FMT_TAG;
                     end else begin
                        phase_in = PH_FSIZE;
                     end
                  end
                  PH_FSIZE: begin
                     if (word_new != wpd_pkg::FMT_CHUNK_SIZE) begin
                        phase_in = PH_ERR;
                        res.error_code = wpd_pkg::ERR_FMT_SIZE;
                     end else begin
                        phase_in = PH_AFMT;
                     end
                  end
                  PH_AFMT: begin
                     if (word_new != 32'd1) begin
                        phase_in = PH_ERR;
                        res.error_code = wpd_pkg::ERR_NOT_PCM;
                     end else begin
                        phase_in = PH_CHAN;
                     end
                  end
                  PH_CHAN: begin
                     if ((word_new != 32'd1) && (word_new != 32'd2)) begin
                        phase_in = PH_ERR;
                        res.error_code = wpd_pkg::ERR_CHANNELS;
                     end else begin
                        chans_in = word_new[1:0];
                        phase_in = PH_RATE;
                     end
                  end
                  PH_RATE: begin
                     rate_in = word_new[wpd_pkg::RATE_WIDTH-1:0];
                     if (rate_low || rate_high) begin
                        phase_in = PH_ERR;
                        res.error_code = wpd_pkg::ERR_RATE;
                     end else begin
                        phase_in = PH_BRATE;
                     end
                  end
                  PH_BRATE: phase_in = PH_ALIGN;
                  PH_ALIGN: phase_in = PH_BITS;
                  PH_BITS: begin
                     if ((word_new != 32'd8) && (word_new != 32'd16) &&
                         (word_new != 32'd32)) begin
                        phase_in = PH_ERR;
                        res.error_code = wpd_pkg::ERR_BITS;
                     end else begin
                        bits_in  = word_new[5:0];
                        phase_in = PH_CID;
                     end
                  end
                  PH_CID: phase_in = (word_new == wpd_pkg::TAG_DATA) ? PH_DSIZE : PH_CSIZE;
                  PH_CSIZE: begin
                     skip_left_in = word_new;
                     phase_in = (word_new == 32'd0) ? PH_CID : PH_SKIP;
                  end
                  PH_DSIZE: begin
                     data_left_in        = word_new;
                     chan_in             = 1'b0;
                     samp_idx_in         = 2'd0;
                     phase_in            = (word_new == 32'd0) ? PH_DONE : PH_DATA;
                     res_valid           = 1'b1;
                     res.kind            = wpd_pkg::KIND_HEADER;
                     res.channel_count   = cur_chans;
                     res.bits_per_sample = cur_bits;
                     res.sample_rate     = cur_rate;
                     res.data_bytes      = word_new;
                  end
                  default: begin
                  end
               endcase
               if (phase_in == PH_ERR) begin
                  res_valid = 1'b1;
                  res.kind  = wpd_pkg::KIND_ERROR;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_RIFF;
         field_idx_ff <= 2'd0;
         word_ff      <= 32'd0;
         chans_ff     <= 2'd0;
         bits_ff      <= 6'd0;
         rate_ff      <= '0;
         data_left_ff <= 32'd0;
         skip_left_ff <= 32'd0;
         chan_ff      <= 1'b0;
         samp_idx_ff  <= 2'd0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         field_idx_ff <= field_idx_in;
         word_ff      <= word_in;
         chans_ff     <= chans_in;
         bits_ff      <= bits_in;
         rate_ff      <= rate_in;
         data_left_ff <= data_left_in;
         skip_left_ff <= skip_left_in;
         chan_ff      <= chan_in;
         samp_idx_ff  <= samp_idx_in;
      end
   end

   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      (accept && !file_start && phase_ff == PH_ERR) |=> (phase_ff == PH_ERR))
      else $error("error phase left without a file start");

   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && !file_start && (phase_ff == PH_ERR || phase_ff == PH_DONE)) |-> !res_valid)
      else $error("result produced after the end of parsing");

   a_data_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (data_left_ff != 32'd0))
      else $error("data phase with no bytes left");

   a_skip_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SKIP) |-> (skip_left_ff != 32'd0))
      else $error("skip phase with no bytes left");

endmodule
`default_nettype wire

// ----- design/wpd_out_buf.sv -----
// Two-entry result buffer: an output register and a skid register.
// Depends on wpd_pkg for the result type.
`default_nettype none
module wpd_out_buf (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wpd_pkg::rsp_type      in_data,
   output logic                  in_ready,
   output logic                  out_valid,
   output wpd_pkg::rsp_type      out_data,
   input  wire logic             out_ready
);

   logic             main_valid_ff;
   wpd_pkg::rsp_type main_data_ff;
   logic             skid_valid_ff;
   wpd_pkg::rsp_type skid_data_ff;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_ready || !main_valid_ff) begin
         main_valid_ff <= skid_valid_ff || in_valid;
         skid_valid_ff <= 1'b0;
         main_data_ff  <= skid_valid_ff ? skid_data_ff : in_data;
      end else if (in_valid && !skid_valid_ff) begin
         skid_valid_ff <= 1'b1;
         skid_data_ff  <= in_data;
      end
   end

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid register holds a transfer while the output register is empty");

endmodule
`default_nettype wire

// ----- design/wav_pcm_stream_decoder_core.sv -----
// Each file byte is one transfer; the block accepts one byte in every cycle in which
// req_tready is high. The parser updates its state at the byte's transfer and its
// result, if any, is registered in the two-entry output buffer, behind older results.
// The buffer holds results, so req_tready drops only after two results wait untaken;
// it does not depend on rsp_tready in the same cycle. No clearing pass follows reset.
// Depends on wpd_pkg, wpd_parser and wpd_out_buf.
`default_nettype none
module wav_pcm_stream_decoder_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,  // data_byte
   input  wire logic        req_tuser,  // file_start
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // sample[15:0], channel[16], error_code[20:17], channel_count[22:21],
   // bits_per_sample[28:23], sample_rate[46:29], data_bytes[78:47], zero[79]
   output logic [79:0]      rsp_tdata,
   output logic [1:0]       rsp_tuser,  // kind
   output logic             rsp_tlast,  // last_sample
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [wpd_pkg::RATE_WIDTH-1:0] min_rate_ff;
   logic [wpd_pkg::RATE_WIDTH-1:0] max_rate_ff;
   logic                           csr_write;
   logic                           req_accept;
   logic                           res_valid;
   wpd_pkg::rsp_type               res;
   wpd_pkg::rsp_type               rsp;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = {{(32-wpd_pkg::RATE_WIDTH){1'b0}},
                        (csr_paddr[2] == wpd_pkg::CSR_IDX_MAX_RATE) ? max_rate_ff : min_rate_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         min_rate_ff <= wpd_pkg::MIN_RATE_RESET;
         max_rate_ff <= wpd_pkg::MAX_RATE_RESET;
      end else if (csr_write) begin
         if (csr_paddr[2] == wpd_pkg::CSR_IDX_MIN_RATE) begin
            min_rate_ff <= csr_pwdata[wpd_pkg::RATE_WIDTH-1:0];
         end else begin
            max_rate_ff <= csr_pwdata[wpd_pkg::RATE_WIDTH-1:0];
         end
      end
   end

   assign req_accept = req_tvalid && req_tready;

   wpd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .data_byte  (req_tdata),
      .file_start (req_tuser),
      .min_rate   (min_rate_ff),
      .max_rate   (max_rate_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   wpd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept && res_valid),
      .in_data   (res),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_data  (rsp),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {1'b0, rsp.data_bytes, rsp.sample_rate, rsp.bits_per_sample,
                       rsp.channel_count, rsp.error_code, rsp.channel, rsp.sample};
   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.last_sample;

endmodule
`default_nettype wire
